FILE: hdl/bsa_pkg.sv
`timescale 1ns / 1ps

package bsa_pkg;

  // Field and register widths
  localparam int REQ_TYPE_W   = 2;
  localparam int SLOT_IDX_W   = 8;
  localparam int ADDR_W       = 32;
  localparam int ESIZE_W      = 16;
  localparam int SCOUNT_W     = 9;
  localparam int STATUS_W     = 2;
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 32;

  // Build depth and bitmap word size
  localparam int DEF_MAX_SLOTS = 256;
  localparam int MAP_WORD_MAX  = 32;

  // Register reset values
  localparam logic [ADDR_W-1:0]   BASE_RESET   = '0;
  localparam logic [ESIZE_W-1:0]  ESIZE_RESET  = 16'd1;
  localparam logic [SCOUNT_W-1:0] SCOUNT_RESET = 9'd256;

  typedef enum logic [REQ_TYPE_W-1:0] {
    REQ_ALLOC_FIRST = 2'd0,
    REQ_ALLOC_AT    = 2'd1,
    REQ_FREE        = 2'd2,
    REQ_QUERY       = 2'd3
  } req_type_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_TAKEN = 2'd2,
    ST_FULL  = 2'd3
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BASE_ADDRESS = 2'd0,
    CFG_ELEMENT_SIZE = 2'd1,
    CFG_SLOT_COUNT   = 2'd2
  } cfg_reg_t;

endpackage

FILE: hdl/bsa_ifs.sv
`timescale 1ns / 1ps

// Request channel
interface bsa_req_if;
  logic                          valid;
  logic                          ready;
  logic [bsa_pkg::REQ_TYPE_W-1:0] req_type;
  logic [bsa_pkg::SLOT_IDX_W-1:0] slot_index;
  logic [bsa_pkg::ADDR_W-1:0]     element_address;

  modport source (output valid, req_type, slot_index, element_address, input ready);
  modport sink   (input valid, req_type, slot_index, element_address, output ready);
endinterface

// Response channel
interface bsa_rsp_if;
  logic                           valid;
  logic                           ready;
  logic [bsa_pkg::STATUS_W-1:0]   status;
  logic [bsa_pkg::SLOT_IDX_W-1:0] result_index;
  logic [bsa_pkg::ADDR_W-1:0]     result_address;
  logic                           occupied;

  modport source (output valid, status, result_index, result_address, occupied, input ready);
  modport sink   (input valid, status, result_index, result_address, occupied, output ready);
endinterface

FILE: hdl/bsa_div.sv
`timescale 1ns / 1ps

// Restoring divider, one quotient bit per cycle
module bsa_div #(
  parameter int DIVIDEND_W = bsa_pkg::ADDR_W,
  parameter int DIVISOR_W  = bsa_pkg::ESIZE_W
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [DIVIDEND_W-1:0] dividend,
  input  logic [DIVISOR_W-1:0]  divisor,
  output logic                  done,
  output logic [DIVIDEND_W-1:0] quotient
);

  localparam int CNT_W = $clog2(DIVIDEND_W + 1);

  logic                  busy;
  logic [CNT_W-1:0]      cnt;
  logic [DIVIDEND_W-1:0] quo;
  logic [DIVISOR_W-1:0]  rem;
  logic [DIVISOR_W-1:0]  dvs;
  logic [DIVISOR_W:0]    shifted;
  logic [DIVISOR_W:0]    diff;
  logic                  fits;

  // One trial subtraction
  assign shifted = {rem, quo[DIVIDEND_W-1]};
  assign diff    = shifted - {1'b0, dvs};
  assign fits    = shifted >= {1'b0, dvs};

  // Step control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(DIVIDEND_W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
      dvs <= divisor;
    end else if (busy) begin
      quo <= {quo[DIVIDEND_W-2:0], fits};
      rem <= fits ? diff[DIVISOR_W-1:0] : shifted[DIVISOR_W-1:0];
    end
  end

  assign quotient = quo;

endmodule

FILE: hdl/bsa_map.sv
`timescale 1ns / 1ps

// Occupancy bitmap: word memory, one read and one write port,
// registered read data, per-word valid bits so reset clears the map at once
module bsa_map #(
  parameter int WORD_W  = bsa_pkg::MAP_WORD_MAX,
  parameter int WORDS   = bsa_pkg::DEF_MAX_SLOTS / bsa_pkg::MAP_WORD_MAX,
  parameter int WADDR_W = (WORDS > 1) ? $clog2(WORDS) : 1
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               rd_en,
  input  logic [WADDR_W-1:0] rd_addr,
  output logic [WORD_W-1:0]  rd_data,
  input  logic               wr_en,
  input  logic [WADDR_W-1:0] wr_addr,
  input  logic [WORD_W-1:0]  wr_data
);

  logic [WORD_W-1:0] mem [WORDS];
  logic [WORDS-1:0]  word_valid;
  logic [WORD_W-1:0] rd_word;
  logic              rd_valid;

  // Storage array
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_word <= mem[rd_addr];
    end
  end

  // Written-since-reset flags
  always_ff @(posedge clk) begin
    if (rst) begin
      word_valid <= '0;
      rd_valid   <= 1'b0;
    end else begin
      if (wr_en) begin
        word_valid[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_valid <= word_valid[rd_addr];
      end
    end
  end

  // Unwritten words read as all free
  assign rd_data = rd_valid ? rd_word : '0;

endmodule

FILE: hdl/bitmap_slot_allocator.sv
`timescale 1ns / 1ps
// Bitmap slot allocator. One request in flight; the next is taken from the cycle its
// response goes valid. Query reads the slot's map word; allocate-at-index reads it and,
// when free, sets the bit and forms the address by a multiply and an add; out-of-range
// index or below-base free goes straight to the response; allocate-first-free scans map
// words, at most 8 at 256; free runs the 32-step bit-serial divider, then clears the bit if in range.
// Synchronous active-high reset frees every slot and loads base 0, element size 1, count 256.
module bitmap_slot_allocator #(
  parameter int MAX_SLOTS = bsa_pkg::DEF_MAX_SLOTS
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [bsa_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bsa_pkg::CFG_DATA_W-1:0] cfg_wdata,
  bsa_req_if.sink                        req,
  bsa_rsp_if.source                      rsp
);

  import bsa_pkg::*;

  localparam int IDX_W   = $clog2(MAX_SLOTS);
  localparam int CNT_W   = $clog2(MAX_SLOTS + 1);
  localparam int WORD_W  = (MAX_SLOTS < MAP_WORD_MAX) ? MAX_SLOTS : MAP_WORD_MAX;
  localparam int BIT_W   = $clog2(WORD_W);
  localparam int WORDS   = (MAX_SLOTS + WORD_W - 1) / WORD_W;
  localparam int WADDR_W = (WORDS > 1) ? $clog2(WORDS) : 1;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN_RD,
    S_SCAN_CHK,
    S_DIV_WAIT,
    S_WORD_RD,
    S_WORD_CHK,
    S_MUL,
    S_ADD,
    S_FINISH
  } state_t;

  state_t state;

  // Configuration registers
  logic [ADDR_W-1:0]   base_address;
  logic [ESIZE_W-1:0]  element_size;
  logic [SCOUNT_W-1:0] slot_count;

  // Request in progress
  req_type_t            req_kind;
  logic [IDX_W-1:0]     idx;
  logic [WADDR_W-1:0]   scan_w;
  logic [IDX_W+ESIZE_W-1:0] prod;
  status_t              res_status;
  logic [ADDR_W-1:0]    res_address;
  logic                 res_occ;

  // Response register
  logic                  rsp_valid;
  status_t               out_status;
  logic [SLOT_IDX_W-1:0] out_index;
  logic [ADDR_W-1:0]     out_address;
  logic                  out_occ;

  // Combinational helpers
  logic                  accept;
  logic [CNT_W-1:0]      live;
  logic [ESIZE_W-1:0]    stride;
  logic                  sidx_ok;
  logic                  addr_ge_base;
  logic [IDX_W+SLOT_IDX_W-1:0] sidx_pad;
  logic [SLOT_IDX_W+IDX_W-1:0] ridx_pad;
  logic                  div_start;
  logic                  div_done;
  logic [ADDR_W-1:0]     quotient;
  logic                  map_rd_en;
  logic [WADDR_W-1:0]    map_rd_addr;
  logic [WORD_W-1:0]     map_rd_data;
  logic                  map_wr_en;
  logic [WADDR_W-1:0]    map_wr_addr;
  logic [WORD_W-1:0]     map_wr_data;
  logic [WADDR_W-1:0]    idx_word;
  logic [BIT_W-1:0]      idx_bit;
  logic                  cur_bit;
  logic                  zfound;
  logic [BIT_W-1:0]      zpos;
  logic [IDX_W:0]        cand;
  logic [IDX_W:0]        next_start;
  logic                  cand_ok;
  logic                  scan_end;
  logic                  out_load;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      base_address <= BASE_RESET;
      element_size <= ESIZE_RESET;
      slot_count   <= SCOUNT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_BASE_ADDRESS: base_address <= cfg_wdata[ADDR_W-1:0];
        CFG_ELEMENT_SIZE: element_size <= cfg_wdata[ESIZE_W-1:0];
        CFG_SLOT_COUNT:   slot_count   <= cfg_wdata[SCOUNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Effective count and stride
  assign live   = (32'(slot_count) > 32'(MAX_SLOTS)) ? CNT_W'(MAX_SLOTS) : CNT_W'(slot_count);
  assign stride = (element_size == '0) ? ESIZE_W'(1) : element_size;

  // Request decode
  assign accept       = req.valid && req.ready;
  assign req.ready    = (state == S_IDLE);
  assign sidx_ok      = 32'(req.slot_index) < 32'(live);
  assign addr_ge_base = req.element_address >= base_address;
  assign sidx_pad     = {{IDX_W{1'b0}}, req.slot_index};
  assign div_start    = accept && (req_type_t'(req.req_type) == REQ_FREE) && addr_ge_base;

  // Slot position in the map
  assign idx_word = WADDR_W'(idx >> BIT_W);
  assign idx_bit  = idx[BIT_W-1:0];
  assign cur_bit  = map_rd_data[idx_bit];

  // Lowest free bit of the word just read
  always_comb begin
    zfound = 1'b0;
    zpos   = '0;
    for (int i = WORD_W - 1; i >= 0; i--) begin
      if (!map_rd_data[i]) begin
        zfound = 1'b1;
        zpos   = BIT_W'(i);
      end
    end
  end

  assign cand       = ((IDX_W+1)'(scan_w) << BIT_W) | (IDX_W+1)'(zpos);
  assign next_start = ((IDX_W+1)'(scan_w) + 1'b1) << BIT_W;
  assign cand_ok    = zfound && (cand < (IDX_W+1)'(live));
  assign scan_end   = zfound || (scan_w == WADDR_W'(WORDS - 1)) ||
                      (next_start >= (IDX_W+1)'(live));

  // Map port control
  always_comb begin
    map_rd_en   = (state == S_SCAN_RD) || (state == S_WORD_RD);
    map_rd_addr = (state == S_SCAN_RD) ? scan_w : idx_word;
    map_wr_en   = 1'b0;
    map_wr_addr = idx_word;
    map_wr_data = map_rd_data | (WORD_W'(1) << idx_bit);
    if (state == S_SCAN_CHK) begin
      map_wr_en   = cand_ok;
      map_wr_addr = scan_w;
      map_wr_data = map_rd_data | (WORD_W'(1) << zpos);
    end else if (state == S_WORD_CHK) begin
      if (req_kind == REQ_ALLOC_AT) begin
        map_wr_en = !cur_bit;
      end else if (req_kind == REQ_FREE) begin
        map_wr_en   = 1'b1;
        map_wr_data = map_rd_data & ~(WORD_W'(1) << idx_bit);
      end
    end
  end

  assign out_load = (state == S_FINISH) && (!rsp_valid || rsp.ready);
  assign ridx_pad = {{SLOT_IDX_W{1'b0}}, idx};

  // Sequencer and response register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      if (out_load) begin
        rsp_valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            req_kind    <= req_type_t'(req.req_type);
            scan_w      <= '0;
            res_address <= '0;
            res_occ     <= 1'b0;
            unique case (req_type_t'(req.req_type))
              REQ_ALLOC_FIRST: begin
                idx        <= '0;
                res_status <= ST_OK;
                state      <= S_SCAN_RD;
              end
              REQ_ALLOC_AT, REQ_QUERY: begin
                if (sidx_ok) begin
                  idx        <= sidx_pad[IDX_W-1:0];
                  res_status <= ST_OK;
                  state      <= S_WORD_RD;
                end else begin
                  idx        <= '0;
                  res_status <= ST_RANGE;
                  state      <= S_FINISH;
                end
              end
              REQ_FREE: begin
                idx <= '0;
                if (addr_ge_base) begin
                  res_status <= ST_OK;
                  state      <= S_DIV_WAIT;
                end else begin
                  res_status <= ST_RANGE;
                  state      <= S_FINISH;
                end
              end
              default: begin
                idx        <= '0;
                res_status <= ST_OK;
                state      <= S_FINISH;
              end
            endcase
          end
        end
        S_SCAN_RD: state <= S_SCAN_CHK;
        S_SCAN_CHK: begin
          if (cand_ok) begin
            idx   <= cand[IDX_W-1:0];
            state <= S_MUL;
          end else if (scan_end) begin
            res_status <= ST_FULL;
            state      <= S_FINISH;
          end else begin
            scan_w <= scan_w + 1'b1;
            state  <= S_SCAN_RD;
          end
        end
        S_DIV_WAIT: begin
          if (div_done) begin
            if (quotient >= ADDR_W'(live)) begin
              res_status <= ST_RANGE;
              state      <= S_FINISH;
            end else begin
              idx   <= quotient[IDX_W-1:0];
              state <= S_WORD_RD;
            end
          end
        end
        S_WORD_RD: state <= S_WORD_CHK;
        S_WORD_CHK: begin
          unique case (req_kind)
            REQ_ALLOC_AT: begin
              if (cur_bit) begin
                res_status <= ST_TAKEN;
                idx        <= '0;
                state      <= S_FINISH;
              end else begin
                state <= S_MUL;
              end
            end
            REQ_QUERY: begin
              res_occ <= cur_bit;
              idx     <= '0;
              state   <= S_FINISH;
            end
            default: state <= S_FINISH;
          endcase
        end
        S_MUL: begin
          prod  <= idx * stride;
          state <= S_ADD;
        end
        S_ADD: begin
          res_address <= base_address + ADDR_W'(prod);
          state       <= S_FINISH;
        end
        S_FINISH: begin
          if (out_load) begin
            out_status  <= res_status;
            out_index   <= (res_status == ST_OK) ? ridx_pad[SLOT_IDX_W-1:0] : '0;
            out_address <= res_address;
            out_occ     <= res_occ;
            state       <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign rsp.valid          = rsp_valid;
  assign rsp.status         = out_status;
  assign rsp.result_index   = out_index;
  assign rsp.result_address = out_address;
  assign rsp.occupied       = out_occ;

  // Free-by-address index: (address - base) / stride
  bsa_div #(
    .DIVIDEND_W (ADDR_W),
    .DIVISOR_W  (ESIZE_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (req.element_address - base_address),
    .divisor  (stride),
    .done     (div_done),
    .quotient (quotient)
  );

  bsa_map #(
    .WORD_W  (WORD_W),
    .WORDS   (WORDS),
    .WADDR_W (WADDR_W)
  ) u_map (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (map_rd_en),
    .rd_addr (map_rd_addr),
    .rd_data (map_rd_data),
    .wr_en   (map_wr_en),
    .wr_addr (map_wr_addr),
    .wr_data (map_wr_data)
  );

  // Checks
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready) |=> !req.ready)
    else $error("request taken while another is in progress");

  a_fail_no_addr: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && (rsp.status != ST_OK)) |-> (rsp.result_address == '0))
    else $error("failed request returned an address");

  a_occ_ok: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.occupied) |-> (rsp.status == ST_OK))
    else $error("occupied set on a failed request");

  a_div_owner: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == S_DIV_WAIT))
    else $error("divider finished outside a free request");

endmodule
